[rtl/fru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_pkg: shared types and constants for the float remainder unit
// Format codes, sequencer states, control and status structs and width constants.
// ----------------------------------------------------------------------------
package fru_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned MantW = 54;   // hidden bit plus 52 fraction bits plus one headroom
	localparam int unsigned ExpW  = 13;   // signed exponent range
	localparam int unsigned CntW  = 12;   // exponent difference count

	typedef enum logic {
		FMT_DOUBLE = 1'b0,
		FMT_SINGLE = 1'b1
	} fmt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_LOOP,
		ST_LAST,
		ST_RENORM,
		ST_PACK,
		ST_OUT
	} state_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic norm;
		logic iter;
		logic last;
		logic renorm;
		logic pack;
	} ctl_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic special;
		logic norm_done;
		logic cnt_zero;
		logic rem_zero;
		logic renorm_done;
	} sts_t;

endpackage

[rtl/fru_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_in_if / fru_out_if: valid-ready channels of the remainder unit
// Input carries the format and both operands, output the result.
// ----------------------------------------------------------------------------
interface fru_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [63:0] x_bits;
	logic [63:0] y_bits;
	modport source (output valid, action, x_bits, y_bits, input ready);
	modport sink   (input valid, action, x_bits, y_bits, output ready);
endinterface

interface fru_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] remainder_bits;
	logic        invalid;
	modport source (output valid, remainder_bits, invalid, input ready);
	modport sink   (input valid, remainder_bits, invalid, output ready);
endinterface

[rtl/fru_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_seq: sequencer of the remainder unit
// Steps the shared subtract-shift datapath through its phases.
// ----------------------------------------------------------------------------
module fru_seq
	import fru_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_fire,
	input  logic   out_fire,
	input  sts_t   sts,
	output ctl_t   ctl,
	output logic   in_ready,
	output logic   out_valid
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_fire) state_d = ST_NORM;
			ST_NORM: begin
				if (sts.special)        state_d = ST_OUT;
				else if (sts.norm_done) state_d = ST_LOOP;
			end
			ST_LOOP:   if (sts.cnt_zero) state_d = ST_LAST;
			ST_LAST:   state_d = ST_RENORM;
			ST_RENORM: begin
				if (sts.rem_zero || sts.renorm_done) state_d = ST_PACK;
			end
			ST_PACK:   state_d = ST_OUT;
			ST_OUT:    if (out_fire) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl        = '0;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		unique case (state_q)
			ST_IDLE:   begin in_ready = 1'b1; ctl.load = in_fire; end
			ST_NORM:   ctl.norm = !sts.special && !sts.norm_done;
			ST_LOOP:   ctl.iter = !sts.cnt_zero;
			ST_LAST:   ctl.last = 1'b1;
			ST_RENORM: ctl.renorm = !sts.rem_zero && !sts.renorm_done;
			ST_PACK:   ctl.pack = 1'b1;
			ST_OUT:    out_valid = 1'b1;
			default:   ;
		endcase
	end

endmodule

[rtl/fru_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_dp: datapath of the remainder unit
// Unpack, one-bit normalize, one subtract-shift step per cycle, pack.
// ----------------------------------------------------------------------------
module fru_dp
	import fru_pkg::*;
(
	input  logic              clk,
	input  logic              action,
	input  logic [DataW-1:0]  x_bits,
	input  logic [DataW-1:0]  y_bits,
	input  ctl_t              ctl,
	output sts_t              sts,
	output logic [DataW-1:0]  remainder_bits,
	output logic              invalid
);

	logic                    sgl_q;
	logic [DataW-1:0]        xs_q;
	logic [MantW-1:0]        mx_q, my_q;
	logic signed [ExpW-1:0]  ex_q, ey_q, e_q;
	logic [CntW-1:0]         cnt_q;
	logic                    special_q;
	logic [DataW-1:0]        res_q;
	logic                    inv_q;

	// format-dependent load
	logic [DataW-1:0]       sgnb, magm, hid, infp, qnan, xm, ym, ax, ay;
	logic [5:0]             mb;
	logic signed [ExpW-1:0] emin;
	logic [MantW-1:0]       hid_n;

	always_comb begin
		if (fmt_t'(action) == FMT_SINGLE) begin
			sgnb = 64'h0000_0000_8000_0000; hid = 64'h0080_0000; mb = 6'd23;
			infp = 64'h7f80_0000; qnan = 64'h7fc0_0000;
		end else begin
			sgnb = 64'h8000_0000_0000_0000; hid = 64'h0010_0000_0000_0000; mb = 6'd52;
			infp = 64'h7ff0_0000_0000_0000; qnan = 64'h7ff8_0000_0000_0000;
		end
		magm = sgnb - 64'd1;
		xm   = x_bits & (sgnb | magm);
		ym   = y_bits & (sgnb | magm);
		ax   = xm & magm;
		ay   = ym & magm;
	end

	// current-format constants for the working phases
	always_comb begin
		hid_n = sgl_q ? MantW'(64'h0080_0000) : MantW'(64'h0010_0000_0000_0000);
		emin  = sgl_q ? -ExpW'(13'sd126) : -ExpW'(13'sd1022);
	end

	logic [MantW-1:0] diff;
	logic             ge;
	logic [MantW-1:0] step;
	assign ge   = mx_q >= my_q;
	assign diff = mx_q - my_q;
	assign step = ge ? diff : mx_q;

	logic signed [ExpW-1:0] sh;
	logic [MantW-1:0]       dn;
	assign sh = emin - e_q;
	assign dn = (sh >= ExpW'(MantW)) ? '0 : (mx_q >> sh[5:0]);

	logic                   xnorm, ynorm;
	logic signed [ExpW-1:0] emin_l, exl, eyl;
	logic [MantW-1:0]       mxl, myl;

	always_comb begin
		emin_l = (fmt_t'(action) == FMT_SINGLE) ? -ExpW'(13'sd126) : -ExpW'(13'sd1022);
		xnorm  = ax >= hid;
		ynorm  = ay >= hid;
		exl    = xnorm ? ExpW'(ax >> mb) + emin_l - ExpW'(1) : emin_l;
		eyl    = ynorm ? ExpW'(ay >> mb) + emin_l - ExpW'(1) : emin_l;
		mxl    = xnorm ? MantW'(hid | (ax & (hid - 64'd1))) : MantW'(ax);
		myl    = ynorm ? MantW'(hid | (ay & (hid - 64'd1))) : MantW'(ay);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sgl_q     <= action;
			xs_q      <= xm & sgnb;
			mx_q      <= mxl;
			my_q      <= myl;
			ex_q      <= exl;
			ey_q      <= eyl;
			if (ay == '0 || ay > infp || ax >= infp) begin
				res_q <= qnan; inv_q <= 1'b1; special_q <= 1'b1;
			end else if (ax < ay) begin
				res_q <= xm; inv_q <= 1'b0; special_q <= 1'b1;
			end else if (ax == ay) begin
				res_q <= xm & sgnb; inv_q <= 1'b0; special_q <= 1'b1;
			end else begin
				inv_q <= 1'b0; special_q <= 1'b0;
			end
		end else if (ctl.norm) begin
			// one bit per cycle on each operand
			if (mx_q < hid_n) begin mx_q <= mx_q << 1; ex_q <= ex_q - ExpW'(1); end
			if (my_q < hid_n) begin my_q <= my_q << 1; ey_q <= ey_q - ExpW'(1); end
		end else if (ctl.iter) begin
			mx_q  <= step << 1;
			cnt_q <= cnt_q - CntW'(1);
		end else if (ctl.last) begin
			mx_q <= step;
			e_q  <= ey_q;
		end else if (ctl.renorm) begin
			mx_q <= mx_q << 1;
			e_q  <= e_q - ExpW'(1);
		end else if (ctl.pack) begin
			if (mx_q == '0)      res_q <= xs_q;
			else if (e_q < emin) res_q <= DataW'(dn) | xs_q;
			else res_q <= (DataW'(e_q - emin + ExpW'(1)) << (sgl_q ? 23 : 52))
				| DataW'(mx_q - hid_n) | xs_q;
		end
		// track the exponent difference until the loop starts counting down
		if (!ctl.iter) cnt_q <= CntW'(ex_q - ey_q);
	end

	always_comb begin
		sts.special     = special_q;
		sts.norm_done   = !(mx_q < hid_n) && !(my_q < hid_n);
		sts.cnt_zero    = cnt_q == '0;
		sts.rem_zero    = mx_q == '0;
		sts.renorm_done = !(mx_q < hid_n);
	end

	assign remainder_bits = res_q;
	assign invalid        = inv_q;

endmodule

[rtl/float_remainder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_remainder_unit: IEEE 754 truncated remainder, double or single
// Special operands go from the normalize state straight to the output; others pass
// normalize shifts, one step per exponent difference, last step, renormalize, pack.
// One item at a time: a new item is accepted only after the result has been taken;
// the single subtract-shift unit sets this.
// Reset: arst_n clears the sequencer to idle; no other state.
// ----------------------------------------------------------------------------
module float_remainder_unit
	import fru_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	fru_in_if.sink    in_ch,
	fru_out_if.source out_ch
);

	ctl_t ctl;
	sts_t sts;
	logic in_fire, out_fire;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;

	fru_seq u_seq (
		.clk, .arst_n, .in_fire, .out_fire, .sts, .ctl,
		.in_ready(in_ch.ready), .out_valid(out_ch.valid)
	);

	fru_dp u_dp (
		.clk, .action(in_ch.action), .x_bits(in_ch.x_bits), .y_bits(in_ch.y_bits),
		.ctl, .sts, .remainder_bits(out_ch.remainder_bits), .invalid(out_ch.invalid)
	);

endmodule

[rtl/fru_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_checker: port-level checks of the remainder unit
// One item in flight, results held while stalled.
// ----------------------------------------------------------------------------
module fru_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_bits,
	input logic        out_inv
);

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bits))
		else $error("result dropped");
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_inv |-> (out_bits == 64'h7ff8000000000000
		|| out_bits == 64'h7fc00000)) else $error("bad invalid NaN");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("accepted while busy");

endmodule

bind float_remainder_unit fru_checker u_chk (
	.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_bits(out_ch.remainder_bits), .out_inv(out_ch.invalid)
);
